// ----- design/dtpc_pkg.sv -----
// Shared constants, types and codes of the depth to point cloud block.
package dtpc_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_FRAME_WIDTH = 3'd0;
  localparam logic [2:0] CFG_GRID_STRIDE = 3'd1;
  localparam logic [2:0] CFG_CENTER_COL  = 3'd2;
  localparam logic [2:0] CFG_CENTER_ROW  = 3'd3;
  localparam logic [2:0] CFG_INV_FOC_X   = 3'd4;
  localparam logic [2:0] CFG_INV_FOC_Y   = 3'd5;

  // Configuration reset values
  localparam logic [12:0] RST_FRAME_WIDTH = 13'd640;
  localparam logic [6:0]  RST_GRID_STRIDE = 7'd5;
  localparam logic [15:0] RST_CENTER_COL  = 16'd5120;
  localparam logic [15:0] RST_CENTER_ROW  = 16'd3840;
  localparam logic [23:0] RST_INV_FOC_X   = 24'd33554;
  localparam logic [23:0] RST_INV_FOC_Y   = 24'd33554;

  // Grid and arithmetic constants
  localparam logic [6:0] MAX_STRIDE    = 7'd64;
  localparam int         FRAC_BITS     = 28;
  localparam int         COORD_W       = 21;
  localparam int         COORD_POS_MAX = 1048575;
  localparam int         COORD_NEG_MAX = 1048576;
  localparam int         INV_SPLIT     = 12;

  // Point queue geometry
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL1,
    BK_MUL2,
    BK_SUM,
    BK_OUT
  } back_state_t;

  // Queue status seen by both ends
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

// ----- design/depth_to_point_cloud.sv -----
// Top level of the depth to point cloud block: configuration registers and wiring.
//
// Usage: pixels of a depth raster enter on the in_ channel (valid/stall), one
// transaction per pixel, with in_start_of_frame marking column 0, row 0. The
// block counts column and row, keeps pixels on the stride grid with valid depth
// and emits one 3D point (x, y, z in mm plus colour) per kept pixel on the out_
// channel. The user must see that registers are written on the cfg_ port only
// while the block is idle; the block itself does not enforce this.
// Throughput: the front end takes one pixel per cycle while in_stall is low.
// Each kept point passes through the back-end sequencer states (pop, depth
// multiply, split reciprocal multiply, round and saturate, output hold), and the
// next point is popped only after the last leaves the output hold; a 4-entry
// point queue absorbs bursts, and in_stall rises only when it is full.
// Path: a kept pixel goes through the queue and the sequencer to out_valid.
// Stall: while out_stall is high the result holds in the output register, the
// back end waits and the front end keeps taking pixels until the queue fills.
// Reset: rst_n (synchronous) clears position counters, empties the queue,
// drops out_valid and loads every configuration register with its reset value.
module depth_to_point_cloud import dtpc_pkg::*; #(
  parameter int MAX_WIDTH_BITS = 12
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_start_of_frame,
  input  logic [15:0]               in_depth_mm,
  input  logic                      in_depth_valid,
  input  logic [7:0]                in_red_in,
  input  logic [7:0]                in_green_in,
  input  logic [7:0]                in_blue_in,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] out_point_x_mm,
  output logic signed [COORD_W-1:0] out_point_y_mm,
  output logic [15:0]               out_point_z_mm,
  output logic [7:0]                out_red_out,
  output logic [7:0]                out_green_out,
  output logic [7:0]                out_blue_out,
  input  logic                      cfg_wr_en,
  input  logic [2:0]                cfg_index,
  input  logic [23:0]               cfg_wr_data
);

  localparam int ENTRY_W = 2 * MAX_WIDTH_BITS + 40;

  logic [12:0] frame_width_r;
  logic [6:0]  grid_stride_r;
  logic [15:0] center_col_r, center_row_r;
  logic [23:0] inv_foc_x_r, inv_foc_y_r;

  q_status_t            q_status;
  logic                 push, pop;
  logic [ENTRY_W-1:0]   push_data, rd_data;

  // Write configuration registers; ignore indexes beyond the list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r <= RST_FRAME_WIDTH;
      grid_stride_r <= RST_GRID_STRIDE;
      center_col_r  <= RST_CENTER_COL;
      center_row_r  <= RST_CENTER_ROW;
      inv_foc_x_r   <= RST_INV_FOC_X;
      inv_foc_y_r   <= RST_INV_FOC_Y;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_FRAME_WIDTH: frame_width_r <= cfg_wr_data[12:0];
        CFG_GRID_STRIDE: grid_stride_r <= cfg_wr_data[6:0];
        CFG_CENTER_COL:  center_col_r  <= cfg_wr_data[15:0];
        CFG_CENTER_ROW:  center_row_r  <= cfg_wr_data[15:0];
        CFG_INV_FOC_X:   inv_foc_x_r   <= cfg_wr_data;
        CFG_INV_FOC_Y:   inv_foc_y_r   <= cfg_wr_data;
        default: begin
        end
      endcase
    end
  end

  dtpc_front #(.POS_W(MAX_WIDTH_BITS)) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_start_of_frame (in_start_of_frame),
    .in_depth_mm       (in_depth_mm),
    .in_depth_valid    (in_depth_valid),
    .in_red_in         (in_red_in),
    .in_green_in       (in_green_in),
    .in_blue_in        (in_blue_in),
    .frame_width       (frame_width_r),
    .grid_stride       (grid_stride_r),
    .q_status          (q_status),
    .push              (push),
    .push_data         (push_data)
  );

  dtpc_queue #(.DATA_W(ENTRY_W)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (push_data),
    .pop     (pop),
    .rd_data (rd_data),
    .status  (q_status)
  );

  dtpc_back #(.POS_W(MAX_WIDTH_BITS)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_status        (q_status),
    .rd_data         (rd_data),
    .pop             (pop),
    .center_col_q4   (center_col_r),
    .center_row_q4   (center_row_r),
    .inv_focal_x_q24 (inv_foc_x_r),
    .inv_focal_y_q24 (inv_foc_y_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_point_x_mm  (out_point_x_mm),
    .out_point_y_mm  (out_point_y_mm),
    .out_point_z_mm  (out_point_z_mm),
    .out_red_out     (out_red_out),
    .out_green_out   (out_green_out),
    .out_blue_out    (out_blue_out)
  );

endmodule

// ----- design/dtpc_front.sv -----
// Front end: raster position tracking and grid/validity classification of pixels.
module dtpc_front import dtpc_pkg::*; #(
  parameter int POS_W = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_start_of_frame,
  input  logic [15:0]           in_depth_mm,
  input  logic                  in_depth_valid,
  input  logic [7:0]            in_red_in,
  input  logic [7:0]            in_green_in,
  input  logic [7:0]            in_blue_in,
  input  logic [12:0]           frame_width,
  input  logic [6:0]            grid_stride,
  input  q_status_t             q_status,
  output logic                  push,
  output logic [2*POS_W+39:0]   push_data
);

  localparam int CW = (POS_W + 1 > 13) ? POS_W + 1 : 13;
  localparam logic [CW-1:0] MAX_W = CW'(2 ** POS_W);

  logic [POS_W-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [5:0]       cph_r, cph_nxt, rph_r, rph_nxt;

  logic [CW-1:0]    fw_ext;
  logic [POS_W:0]   width_eff;
  logic [6:0]       stride_eff;
  logic [POS_W-1:0] col_cur, row_cur;
  logic [5:0]       cph_cur, rph_cur;
  logic [POS_W:0]   col_inc;
  logic [6:0]       cph_inc, rph_inc;
  logic             end_row;
  logic             accept;
  logic             keep;

  // Clamp width and stride to their legal ranges
  always_comb begin
    fw_ext = CW'(frame_width);
    if (fw_ext == '0) begin
      width_eff = (POS_W+1)'(1);
    end else if (fw_ext > MAX_W) begin
      width_eff = MAX_W[POS_W:0];
    end else begin
      width_eff = fw_ext[POS_W:0];
    end
    if (grid_stride == 7'd0) begin
      stride_eff = 7'd1;
    end else if (grid_stride > MAX_STRIDE) begin
      stride_eff = MAX_STRIDE;
    end else begin
      stride_eff = grid_stride;
    end
  end

  // Classify the pixel and advance the raster position
  always_comb begin
    col_cur = in_start_of_frame ? '0 : col_r;
    row_cur = in_start_of_frame ? '0 : row_r;
    cph_cur = in_start_of_frame ? '0 : cph_r;
    rph_cur = in_start_of_frame ? '0 : rph_r;
    col_inc = {1'b0, col_cur} + (POS_W+1)'(1);
    cph_inc = {1'b0, cph_cur} + 7'd1;
    rph_inc = {1'b0, rph_cur} + 7'd1;
    end_row = (col_inc >= width_eff);
    keep    = (cph_cur == 6'd0) && (rph_cur == 6'd0) && in_depth_valid;
    if (end_row) begin
      col_nxt = '0;
      cph_nxt = '0;
      row_nxt = row_cur + POS_W'(1);
      rph_nxt = (rph_inc >= stride_eff) ? 6'd0 : rph_inc[5:0];
    end else begin
      col_nxt = col_inc[POS_W-1:0];
      cph_nxt = (cph_inc >= stride_eff) ? 6'd0 : cph_inc[5:0];
      row_nxt = row_cur;
      rph_nxt = rph_cur;
    end
  end

  assign in_stall  = q_status.full;
  assign accept    = in_valid && !in_stall;
  assign push      = accept && keep;
  assign push_data = {col_cur, row_cur, in_depth_mm, in_red_in, in_green_in, in_blue_in};

  // Hold position on idle, advance on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      cph_r <= '0;
      rph_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      cph_r <= cph_nxt;
      rph_r <= rph_nxt;
    end
  end

endmodule

// ----- design/dtpc_queue.sv -----
// Short FIFO of kept pixels between the front end and the back end.
module dtpc_queue import dtpc_pkg::*; #(
  parameter int DATA_W = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              pop,
  output logic [DATA_W-1:0] rd_data,
  output q_status_t         status
);

  logic [DATA_W-1:0]  mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_PTR_W:0]   count_r;

  assign rd_data      = mem[rd_ptr_r];
  assign status.empty = (count_r == '0);
  assign status.full  = (count_r == (Q_PTR_W+1)'(Q_DEPTH));

  // Write the entry at the tail
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  // Advance pointers and track the fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (Q_PTR_W+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (Q_PTR_W+1)'(1);
      end
    end
  end

endmodule

// ----- design/dtpc_back.sv -----
// Back end: pinhole back-projection sequencer with rounding, saturation and output register.
module dtpc_back import dtpc_pkg::*; #(
  parameter int POS_W = 12
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  q_status_t                 q_status,
  input  logic [2*POS_W+39:0]       rd_data,
  output logic                      pop,
  input  logic [15:0]               center_col_q4,
  input  logic [15:0]               center_row_q4,
  input  logic [23:0]               inv_focal_x_q24,
  input  logic [23:0]               inv_focal_y_q24,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] out_point_x_mm,
  output logic signed [COORD_W-1:0] out_point_y_mm,
  output logic [15:0]               out_point_z_mm,
  output logic [7:0]                out_red_out,
  output logic [7:0]                out_green_out,
  output logic [7:0]                out_blue_out
);

  localparam int DW = (POS_W + 4 > 16) ? POS_W + 4 : 16;
  localparam int ZW = DW + 16;
  localparam int PW = ZW + INV_SPLIT;
  localparam int SW = ZW + 24;
  localparam int MW = SW - FRAC_BITS;

  back_state_t state_r, state_nxt;

  logic [POS_W-1:0] q_col, q_row;
  logic [15:0]      q_depth;
  logic [7:0]       q_red, q_green, q_blue;
  logic [DW-1:0]    pq_col, pq_row, cc_ext, cr_ext;

  logic [DW-1:0]    dx_r, dy_r;
  logic             negx_r, negy_r;
  logic [15:0]      z_r;
  logic [7:0]       red_r, green_r, blue_r;
  logic [ZW-1:0]    pzx_r, pzy_r;
  logic [PW-1:0]    plox_r, phix_r, ploy_r, phiy_r;

  logic                      out_valid_r;
  logic signed [COORD_W-1:0] x_r, y_r;
  logic [15:0]               zo_r;
  logic [7:0]                ro_r, go_r, bo_r;

  // Combine partial products, round half away from zero, saturate and apply sign
  function automatic logic [COORD_W-1:0] round_sat(input logic [PW-1:0] plo,
                                                   input logic [PW-1:0] phi,
                                                   input logic          neg);
    logic [SW-1:0]      acc;
    logic [MW-1:0]      mag;
    logic [MW-1:0]      lim;
    logic [COORD_W-1:0] m21;
    acc = SW'(plo) + (SW'(phi) << INV_SPLIT) + (SW'(1) << (FRAC_BITS - 1));
    mag = acc[SW-1:FRAC_BITS];
    lim = neg ? MW'(COORD_NEG_MAX) : MW'(COORD_POS_MAX);
    if (mag > lim) begin
      mag = lim;
    end
    m21 = mag[COORD_W-1:0];
    return neg ? (~m21 + COORD_W'(1)) : m21;
  endfunction

  // Unpack the queue head and form Q4 positions
  always_comb begin
    {q_col, q_row, q_depth, q_red, q_green, q_blue} = rd_data;
    pq_col = DW'({q_col, 4'b0000});
    pq_row = DW'({q_row, 4'b0000});
    cc_ext = DW'(center_col_q4);
    cr_ext = DW'(center_row_q4);
  end

  // Step the sequencer and pop the next point
  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (!q_status.empty) begin
          pop       = 1'b1;
          state_nxt = BK_MUL1;
        end
      end
      BK_MUL1: state_nxt = BK_MUL2;
      BK_MUL2: state_nxt = BK_SUM;
      BK_SUM:  state_nxt = BK_OUT;
      BK_OUT: begin
        if (!out_stall) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_nxt == BK_OUT);
    end
  end

  // Datapath: offset, depth product, split reciprocal product, result
  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        negx_r  <= pq_col < cc_ext;
        dx_r    <= (pq_col < cc_ext) ? (cc_ext - pq_col) : (pq_col - cc_ext);
        negy_r  <= pq_row < cr_ext;
        dy_r    <= (pq_row < cr_ext) ? (cr_ext - pq_row) : (pq_row - cr_ext);
        z_r     <= q_depth;
        red_r   <= q_red;
        green_r <= q_green;
        blue_r  <= q_blue;
      end
      BK_MUL1: begin
        pzx_r <= ZW'(dx_r) * ZW'(z_r);
        pzy_r <= ZW'(dy_r) * ZW'(z_r);
      end
      BK_MUL2: begin
        plox_r <= PW'(pzx_r) * PW'(inv_focal_x_q24[INV_SPLIT-1:0]);
        phix_r <= PW'(pzx_r) * PW'(inv_focal_x_q24[23:INV_SPLIT]);
        ploy_r <= PW'(pzy_r) * PW'(inv_focal_y_q24[INV_SPLIT-1:0]);
        phiy_r <= PW'(pzy_r) * PW'(inv_focal_y_q24[23:INV_SPLIT]);
      end
      BK_SUM: begin
        x_r  <= signed'(round_sat(plox_r, phix_r, negx_r));
        y_r  <= signed'(round_sat(ploy_r, phiy_r, negy_r));
        zo_r <= z_r;
        ro_r <= red_r;
        go_r <= green_r;
        bo_r <= blue_r;
      end
      default: begin
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_point_x_mm = x_r;
  assign out_point_y_mm = y_r;
  assign out_point_z_mm = zo_r;
  assign out_red_out    = ro_r;
  assign out_green_out  = go_r;
  assign out_blue_out   = bo_r;

endmodule

// ----- design/dtpc_checker.sv -----
// Port-level checker for the depth to point cloud block and its bind.
module dtpc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_point_z_mm
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_point_z_mm))
    else $error("out payload changed while stalled");

  // The sequencer passes through idle after each taken result, so no back-to-back results
  a_out_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> !out_valid)
    else $error("result followed a taken result without a gap");

  // Reset empties the queue and the output register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not cleared after reset");

endmodule

bind depth_to_point_cloud dtpc_checker u_dtpc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_point_z_mm (out_point_z_mm)
);

// ----- test/depth_to_point_cloud_tb.sv -----
// Self-checking testbench of depth_to_point_cloud: directed table, random frames, point compare.
`timescale 1ns / 1ps

module depth_to_point_cloud_tb;
  import dtpc_pkg::*;

  localparam int CLK_PERIOD      = 12;
  localparam int RESET_CYCLES    = 9;
  localparam int POS_BITS        = 12;
  localparam int MAX_COLS        = 1 << POS_BITS;
  localparam int SETTLE_CYCLES   = 16;
  localparam int DRAIN_LIMIT     = 4000;
  localparam int HOLD_CYCLES     = 300;
  localparam int FILL_ITEMS      = 40;
  localparam int SEGMENTS        = 8;
  localparam int ROW_WALK_ITEMS  = 250;
  localparam int SEND_IDLE_PCT   = 21;
  localparam int RECV_IDLE_PCT   = 47;
  localparam int MAX_PRINTS      = 100;
  localparam int WATCHDOG_CYCLES = 400000;

  // Register indexes past the end of the register list
  localparam logic [2:0] CFG_SPARE_LO = 3'd6;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;

  typedef enum logic [1:0] {PLAN_RECV_HEAVY, PLAN_SEND_HEAVY, PLAN_NO_IDLE} idle_plan_t;
  typedef enum logic {ROW_PIXEL, ROW_REG} row_kind_t;
  typedef enum logic [1:0] {CHK_PRED, CHK_TYPED, CHK_NONE} row_check_t;

  typedef struct packed {
    logic        sof;
    logic [15:0] depth;
    logic        dvalid;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } pixel_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [15:0]               z;
    logic [7:0]                red;
    logic [7:0]                green;
    logic [7:0]                blue;
  } point_t;

  typedef struct {
    row_kind_t   kind;
    logic [2:0]  idx;
    logic [23:0] data;
    pixel_t      px;
    row_check_t  chk;
    int          x;
    int          y;
  } stim_row_t;

  typedef logic [5:0][23:0] reg_image_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      in_start_of_frame = 1'b0;
  logic [15:0]               in_depth_mm = '0;
  logic                      in_depth_valid = 1'b0;
  logic [7:0]                in_red_in = '0;
  logic [7:0]                in_green_in = '0;
  logic [7:0]                in_blue_in = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [COORD_W-1:0] out_point_x_mm;
  logic signed [COORD_W-1:0] out_point_y_mm;
  logic [15:0]               out_point_z_mm;
  logic [7:0]                out_red_out;
  logic [7:0]                out_green_out;
  logic [7:0]                out_blue_out;
  logic                      cfg_wr_en = 1'b0;
  logic [2:0]                cfg_index = '0;
  logic [23:0]               cfg_wr_data = '0;

  // Predictor copy of the registers and the raster position
  logic [12:0] cfg_width  = RST_FRAME_WIDTH;
  logic [6:0]  cfg_stride = RST_GRID_STRIDE;
  logic [15:0] cfg_cx     = RST_CENTER_COL;
  logic [15:0] cfg_cy     = RST_CENTER_ROW;
  logic [23:0] cfg_ifx    = RST_INV_FOC_X;
  logic [23:0] cfg_ify    = RST_INV_FOC_Y;
  int unsigned col_pos = 0, row_pos = 0, col_phase = 0, row_phase = 0;

  point_t    pending_points[$];
  stim_row_t dir_rows[$];
  int        mismatch_count = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        hold_requests = 0;

  depth_to_point_cloud #(.MAX_WIDTH_BITS(POS_BITS)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_start_of_frame (in_start_of_frame),
    .in_depth_mm       (in_depth_mm),
    .in_depth_valid    (in_depth_valid),
    .in_red_in         (in_red_in),
    .in_green_in       (in_green_in),
    .in_blue_in        (in_blue_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_point_x_mm    (out_point_x_mm),
    .out_point_y_mm    (out_point_y_mm),
    .out_point_z_mm    (out_point_z_mm),
    .out_red_out       (out_red_out),
    .out_green_out     (out_green_out),
    .out_blue_out      (out_blue_out),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wr_data       (cfg_wr_data)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  task automatic report_mismatch(input string field, input longint got, input longint want);
    if (mismatch_count < MAX_PRINTS) begin
      $display("MISMATCH %s: got %0d, expected %0d", field, got, want);
    end
    mismatch_count++;
  endtask

  // One axis: (pos*16 - center) * z * inv in Q28, round half away, saturate
  function automatic logic [COORD_W-1:0] project_axis(input int unsigned pos,
      input int unsigned center, input int unsigned depth, input int unsigned inv);
    longint unsigned pos_q4, offset_mag, mag;
    bit neg;
    pos_q4 = longint'(pos) << 4;
    neg = pos_q4 < center;
    offset_mag = neg ? (center - pos_q4) : (pos_q4 - center);
    mag = (offset_mag * depth * inv + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (neg) begin
      if (mag > COORD_NEG_MAX) mag = COORD_NEG_MAX;
      mag = ~mag + 64'd1;
    end else if (mag > COORD_POS_MAX) begin
      mag = COORD_POS_MAX;
    end
    return mag[COORD_W-1:0];
  endfunction

  // Back-project one accepted pixel and advance the raster position
  task automatic backproject_pixel(input pixel_t px, output bit emits, output point_t pt);
    int unsigned w, s;
    w = (cfg_width == 0) ? 1 : cfg_width;
    if (w > MAX_COLS) w = MAX_COLS;
    s = (cfg_stride == 0) ? 1 : cfg_stride;
    if (s > MAX_STRIDE) s = MAX_STRIDE;
    if (px.sof) begin
      col_pos = 0;
      row_pos = 0;
      col_phase = 0;
      row_phase = 0;
    end
    emits = (col_phase == 0) && (row_phase == 0) && px.dvalid;
    pt = '0;
    if (emits) begin
      pt.x = project_axis(col_pos, cfg_cx, px.depth, cfg_ifx);
      pt.y = project_axis(row_pos, cfg_cy, px.depth, cfg_ify);
      pt.z = px.depth;
      pt.red = px.red;
      pt.green = px.green;
      pt.blue = px.blue;
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      col_phase = 0;
      row_pos = (row_pos + 1) % MAX_COLS;
      row_phase = (row_phase + 1 >= s) ? 0 : row_phase + 1;
    end else begin
      col_pos = col_pos + 1;
      col_phase = (col_phase + 1 >= s) ? 0 : col_phase + 1;
    end
  endtask

  function automatic pixel_t random_pixel(input int sof_pct);
    pixel_t px;
    px.sof = $urandom_range(99) < sof_pct;
    case ($urandom_range(7))
      0: px.depth = 16'd0;
      1: px.depth = 16'hFFFF;
      default: px.depth = 16'($urandom_range(65535));
    endcase
    px.dvalid = $urandom_range(99) < 85;
    px.red = 8'($urandom_range(255));
    px.green = 8'($urandom_range(255));
    px.blue = 8'($urandom_range(255));
    return px;
  endfunction

  task automatic put_payload(input pixel_t px);
    in_start_of_frame <= px.sof;
    in_depth_mm <= px.depth;
    in_depth_valid <= px.dvalid;
    in_red_in <= px.red;
    in_green_in <= px.green;
    in_blue_in <= px.blue;
  endtask

  // Offer one pixel, hold it until accepted, then record what it should produce
  task automatic send_pixel(input pixel_t px, input row_check_t chk, input int tx, input int ty);
    bit emits;
    point_t pt;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      put_payload(random_pixel(50));
      @(posedge clk);
    end
    in_valid <= 1'b1;
    put_payload(px);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    backproject_pixel(px, emits, pt);
    case (chk)
      CHK_PRED: if (emits) pending_points.insert(pending_points.size(), pt);
      CHK_TYPED: begin
        pt.x = tx[COORD_W-1:0];
        pt.y = ty[COORD_W-1:0];
        pt.z = px.depth;
        pt.red = px.red;
        pt.green = px.green;
        pt.blue = px.blue;
        pending_points.insert(pending_points.size(), pt);
      end
      default: ;
    endcase
  endtask

  // Drop valid, wait for every pending point, then let in-flight pixels clear
  task automatic settle_block();
    int n;
    in_valid <= 1'b0;
    for (n = 0; n < DRAIN_LIMIT && pending_points.size() != 0; n++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register; the caller lowers the write enable after the last one
  task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= data;
    @(posedge clk);
    case (idx)
      CFG_FRAME_WIDTH: cfg_width = data[12:0];
      CFG_GRID_STRIDE: cfg_stride = data[6:0];
      CFG_CENTER_COL:  cfg_cx = data[15:0];
      CFG_CENTER_ROW:  cfg_cy = data[15:0];
      CFG_INV_FOC_X:   cfg_ifx = data;
      CFG_INV_FOC_Y:   cfg_ify = data;
      default: ;
    endcase
  endtask

  task automatic load_settings(input reg_image_t img);
    settle_block();
    write_reg(CFG_FRAME_WIDTH, img[CFG_FRAME_WIDTH]);
    write_reg(CFG_GRID_STRIDE, img[CFG_GRID_STRIDE]);
    write_reg(CFG_CENTER_COL, img[CFG_CENTER_COL]);
    write_reg(CFG_CENTER_ROW, img[CFG_CENTER_ROW]);
    write_reg(CFG_INV_FOC_X, img[CFG_INV_FOC_X]);
    write_reg(CFG_INV_FOC_Y, img[CFG_INV_FOC_Y]);
    if ($urandom_range(3) == 0) begin
      write_reg($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, 24'($urandom()));
    end
    cfg_wr_en <= 1'b0;
  endtask

  function automatic reg_image_t random_settings();
    reg_image_t img;
    case ($urandom_range(9))
      0: img[CFG_FRAME_WIDTH] = 24'd0;
      1: img[CFG_FRAME_WIDTH] = 24'd1;
      2: img[CFG_FRAME_WIDTH] = 24'(MAX_COLS);
      3: img[CFG_FRAME_WIDTH] = 24'($urandom_range(MAX_COLS + 1, 8191));
      4: img[CFG_FRAME_WIDTH] = 24'($urandom());
      default: img[CFG_FRAME_WIDTH] = 24'($urandom_range(2, 40));
    endcase
    case ($urandom_range(9))
      0: img[CFG_GRID_STRIDE] = 24'd0;
      1: img[CFG_GRID_STRIDE] = 24'(MAX_STRIDE);
      2: img[CFG_GRID_STRIDE] = 24'($urandom_range(65, 127));
      3: img[CFG_GRID_STRIDE] = 24'($urandom());
      4: img[CFG_GRID_STRIDE] = 24'd1;
      default: img[CFG_GRID_STRIDE] = 24'($urandom_range(1, 4));
    endcase
    for (int i = 0; i < 2; i++) begin
      case ($urandom_range(7))
        0: img[CFG_CENTER_COL + i] = 24'd0;
        1: img[CFG_CENTER_COL + i] = 24'hFFFF;
        2: img[CFG_CENTER_COL + i] = 24'($urandom_range(65535));
        3: img[CFG_CENTER_COL + i] = 24'($urandom());
        default: img[CFG_CENTER_COL + i] = 24'($urandom_range(700));
      endcase
      case ($urandom_range(7))
        0: img[CFG_INV_FOC_X + i] = 24'd1;
        1: img[CFG_INV_FOC_X + i] = 24'hFFFFFF;
        2: img[CFG_INV_FOC_X + i] = 24'($urandom());
        3: img[CFG_INV_FOC_X + i] = 24'd0;
        default: img[CFG_INV_FOC_X + i] = 24'($urandom_range(20000, 60000));
      endcase
    end
    return img;
  endfunction

  // Random frames: most segments open on a start of frame, rare restarts inside
  task automatic run_segment(input int items);
    pixel_t px;
    for (int i = 0; i < items; i++) begin
      px = random_pixel(1);
      if (i == 0) px.sof = $urandom_range(3) != 0;
      send_pixel(px, CHK_PRED, 0, 0);
    end
  endtask

  task automatic run_plan(input idle_plan_t plan);
    reg_image_t img;
    pixel_t px;
    case (plan)
      PLAN_RECV_HEAVY: begin
        send_idle_pct = SEND_IDLE_PCT;
        recv_idle_pct = RECV_IDLE_PCT;
      end
      PLAN_SEND_HEAVY: begin
        send_idle_pct = RECV_IDLE_PCT;
        recv_idle_pct = SEND_IDLE_PCT;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
    // Fill the point queue behind a long receiver hold-off, then pause until empty
    if (plan == PLAN_RECV_HEAVY) begin
      img = '0;
      img[CFG_FRAME_WIDTH] = 24'd30;
      img[CFG_GRID_STRIDE] = 24'd1;
      img[CFG_CENTER_COL] = 24'd240;
      img[CFG_CENTER_ROW] = 24'd240;
      img[CFG_INV_FOC_X] = RST_INV_FOC_X;
      img[CFG_INV_FOC_Y] = RST_INV_FOC_Y;
      load_settings(img);
      hold_requests++;
      for (int i = 0; i < FILL_ITEMS; i++) begin
        px = random_pixel(0);
        px.dvalid = 1'b1;
        px.sof = (i == 0);
        send_pixel(px, CHK_PRED, 0, 0);
      end
      settle_block();
    end
    repeat (SEGMENTS) begin
      load_settings(random_settings());
      run_segment($urandom_range(40, 80));
    end
    // One-pixel rows with an odd stride: walk the row counter and row phase
    if (plan == PLAN_NO_IDLE) begin
      img = random_settings();
      img[CFG_FRAME_WIDTH] = 24'd1;
      img[CFG_GRID_STRIDE] = 24'd3;
      load_settings(img);
      for (int i = 0; i < ROW_WALK_ITEMS; i++) begin
        px = random_pixel(0);
        px.sof = (i == 0);
        px.dvalid = 1'($urandom_range(1));
        send_pixel(px, CHK_PRED, 0, 0);
      end
    end
  endtask

  function automatic stim_row_t pixel_row(input logic sof, input logic [15:0] depth,
      input logic dvalid, input logic [23:0] rgb, input row_check_t chk,
      input int x = 0, input int y = 0);
    stim_row_t row;
    row.kind = ROW_PIXEL;
    row.idx = '0;
    row.data = '0;
    row.px = {sof, depth, dvalid, rgb};
    row.chk = chk;
    row.x = x;
    row.y = y;
    return row;
  endfunction

  function automatic stim_row_t reg_row(input logic [2:0] idx, input logic [23:0] data);
    stim_row_t row;
    row.kind = ROW_REG;
    row.idx = idx;
    row.data = data;
    row.px = '0;
    row.chk = CHK_NONE;
    row.x = 0;
    row.y = 0;
    return row;
  endfunction

  // Compare each accepted point with the oldest pending one
  always @(posedge clk) begin
    point_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_points.size() == 0) begin
        report_mismatch("point with none pending", 1, 0);
      end else begin
        want = pending_points[0];
        pending_points.delete(0);
        if (out_point_x_mm !== want.x) report_mismatch("point_x_mm", out_point_x_mm, want.x);
        if (out_point_y_mm !== want.y) report_mismatch("point_y_mm", out_point_y_mm, want.y);
        if (out_point_z_mm !== want.z) report_mismatch("point_z_mm", out_point_z_mm, want.z);
        if (out_red_out !== want.red) report_mismatch("red_out", out_red_out, want.red);
        if (out_green_out !== want.green) report_mismatch("green_out", out_green_out, want.green);
        if (out_blue_out !== want.blue) report_mismatch("blue_out", out_blue_out, want.blue);
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested
  initial begin
    int served;
    served = 0;
    forever begin
      @(posedge clk);
      if (served != hold_requests) begin
        served = hold_requests;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  initial begin
    #(WATCHDOG_CYCLES * CLK_PERIOD);
    $display("depth_to_point_cloud verification failed");
    $finish;
  end

  initial begin
    bit writing;
    // Directed rows, starting from the reset register values
    dir_rows.push_back(pixel_row(1'b1, 16'd0, 1'b1, 24'hFF00FF, CHK_TYPED, 0, 0));
    dir_rows.push_back(pixel_row(1'b0, 16'hFFFF, 1'b1, 24'h00FF00, CHK_NONE));
    dir_rows.push_back(pixel_row(1'b1, 16'hFFFF, 1'b0, 24'hFFFFFF, CHK_NONE));
    dir_rows.push_back(pixel_row(1'b0, 16'd1, 1'b1, 24'h000000, CHK_NONE));
    dir_rows.push_back(pixel_row(1'b1, 16'hFFFF, 1'b1, 24'h123456, CHK_PRED));
    // Narrow rows, center at the origin, zero vertical reciprocal
    dir_rows.push_back(reg_row(CFG_FRAME_WIDTH, 24'd3));
    dir_rows.push_back(reg_row(CFG_GRID_STRIDE, 24'd1));
    dir_rows.push_back(reg_row(CFG_CENTER_COL, 24'd0));
    dir_rows.push_back(reg_row(CFG_CENTER_ROW, 24'd0));
    dir_rows.push_back(reg_row(CFG_INV_FOC_X, 24'hFFFFFF));
    dir_rows.push_back(reg_row(CFG_INV_FOC_Y, 24'd0));
    dir_rows.push_back(pixel_row(1'b1, 16'hFFFF, 1'b1, 24'hAA55AA, CHK_TYPED, 0, 0));
    dir_rows.push_back(pixel_row(1'b0, 16'hFFFF, 1'b1, 24'h55AA55, CHK_PRED));
    dir_rows.push_back(pixel_row(1'b0, 16'hFFFF, 1'b1, 24'h0F0F0F, CHK_PRED));
    dir_rows.push_back(pixel_row(1'b0, 16'd300, 1'b1, 24'hF0F0F0, CHK_TYPED, 0, 0));
    // Far center and full reciprocals: both axes saturate negative
    dir_rows.push_back(reg_row(CFG_CENTER_COL, 24'hFFFF));
    dir_rows.push_back(reg_row(CFG_CENTER_ROW, 24'hFFFF));
    dir_rows.push_back(reg_row(CFG_INV_FOC_Y, 24'hFFFFFF));
    dir_rows.push_back(pixel_row(1'b1, 16'hFFFF, 1'b1, 24'h010203, CHK_TYPED,
                                 -COORD_NEG_MAX, -COORD_NEG_MAX));
    dir_rows.push_back(pixel_row(1'b0, 16'hFFFF, 1'b1, 24'h040506, CHK_PRED));
    // Zero width and oversized stride clamp to 1 and the stride limit
    dir_rows.push_back(reg_row(CFG_FRAME_WIDTH, 24'd0));
    dir_rows.push_back(reg_row(CFG_GRID_STRIDE, 24'h7F));
    dir_rows.push_back(reg_row(CFG_CENTER_COL, 24'd0));
    dir_rows.push_back(reg_row(CFG_CENTER_ROW, 24'd0));
    dir_rows.push_back(pixel_row(1'b1, 16'd4000, 1'b1, 24'h808080, CHK_TYPED, 0, 0));
    dir_rows.push_back(pixel_row(1'b0, 16'd4000, 1'b1, 24'h7F7F7F, CHK_NONE));
    // Shrink the stride mid-frame: the row phase past the new limit wraps
    dir_rows.push_back(reg_row(CFG_GRID_STRIDE, 24'd2));
    dir_rows.push_back(pixel_row(1'b0, 16'd4000, 1'b1, 24'h111111, CHK_NONE));
    dir_rows.push_back(pixel_row(1'b0, 16'd4000, 1'b1, 24'h222222, CHK_PRED));
    // Oversized width, zero stride, and writes past the register list
    dir_rows.push_back(reg_row(CFG_FRAME_WIDTH, 24'h1FFF));
    dir_rows.push_back(reg_row(CFG_GRID_STRIDE, 24'd0));
    dir_rows.push_back(reg_row(CFG_SPARE_LO, 24'hFFFFFF));
    dir_rows.push_back(reg_row(CFG_SPARE_HI, 24'd0));
    dir_rows.push_back(pixel_row(1'b0, 16'hFFFF, 1'b1, 24'h333333, CHK_PRED));
    dir_rows.push_back(pixel_row(1'b1, 16'd0, 1'b1, 24'h444444, CHK_TYPED, 0, 0));
    dir_rows.push_back(pixel_row(1'b1, 16'hFFFF, 1'b0, 24'h555555, CHK_NONE));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table; register rows wait for the block to go idle
    send_idle_pct = SEND_IDLE_PCT;
    recv_idle_pct = RECV_IDLE_PCT;
    writing = 1'b0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        if (!writing) settle_block();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
        writing = 1'b1;
      end else begin
        if (writing) cfg_wr_en <= 1'b0;
        writing = 1'b0;
        send_pixel(dir_rows[i].px, dir_rows[i].chk, dir_rows[i].x, dir_rows[i].y);
      end
    end

    run_plan(PLAN_RECV_HEAVY);
    run_plan(PLAN_SEND_HEAVY);
    run_plan(PLAN_NO_IDLE);

    settle_block();
    if (pending_points.size() != 0) begin
      report_mismatch("points never delivered", pending_points.size(), 0);
    end
    if (mismatch_count == 0) begin
      $display("depth_to_point_cloud verification clean");
    end else begin
      $display("depth_to_point_cloud verification failed");
    end
    $finish;
  end

endmodule
